@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the stencil core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CDS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cds assertion failed");
`define CDS_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("cds forbidden condition seen");
`else
`define CDS_ASSERT(lbl, prop)
`define CDS_ASSERT_NEVER(lbl, expr)
`endif

`endif

@@ src/cds_pkg.sv @@
`timescale 1ns / 1ps

package cds_pkg;

  localparam int MaxWidth     = 1024;
  localparam int MaxHeight    = 1024;
  localparam int SampleBits   = 24;
  localparam int RateFracBits = 16;

  localparam int ColW   = $clog2(MaxWidth);
  localparam int RowW   = $clog2(MaxHeight);
  localparam int SizeW  = $clog2(MaxWidth + 1);
  localparam int HSizeW = $clog2(MaxHeight + 1);
  localparam int LimW   = SampleBits - 1;
  localparam int PendW  = 11;
  localparam int AccW   = SampleBits + 4;
  localparam int ProdW  = AccW + RateFracBits + 1;
  localparam int ValW   = AccW + 2;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 23;
  localparam int CfgSizeW = 11;

  localparam int MinSize   = 3;
  localparam int RateReset = 13107;
  localparam int SizeReset = 64;

  localparam int OutDepth = 8;
  localparam int OutPtrW  = $clog2(OutDepth);
  localparam int OutCntW  = $clog2(OutDepth + 1) + 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRate        = 2'd0,
    CfgClampLimit  = 2'd1,
    CfgFrameWidth  = 2'd2,
    CfgFrameHeight = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                         kind;
    logic signed [SampleBits-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] value;
    logic                         frame_end;
  } out_item_t;

  typedef struct packed {
    logic                         emit;
    logic [ColW-1:0]              tc;
    logic                         top;
    logic                         bot;
    logic                         le;
    logic                         ri;
    logic                         corner;
    logic                         frame_end;
    logic signed [SampleBits-1:0] dn;
  } fetch_t;

  typedef struct packed {
    logic                         corner;
    logic                         frame_end;
    logic signed [AccW-1:0]       acc;
    logic signed [SampleBits-1:0] centre;
  } lap_t;

  typedef struct packed {
    logic                         corner;
    logic                         frame_end;
    logic signed [ProdW-1:0]      prod;
    logic signed [SampleBits-1:0] centre;
  } scale_t;

endpackage

@@ src/clamped_diffusion_stencil_core.sv @@
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    in_data_i   (cds_pkg::in_item_t)
// out      output     out_valid_o / out_ready_i  out_data_o  (cds_pkg::out_item_t)
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One input transfer is taken per cycle while in_ready_o is high; a result passes s1_q, s2_q and s3_q.
// Two line memories (1 write, 2 read ports each) and win_q give all neighbours in every cycle.
// After reset a clearing pass zeroes all 1024 entries of both line memories; no input is taken.
// Input stalls while eight results are queued or in flight; an eight-entry queue holds them.
// Configuration transfers are always taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clamped_diffusion_stencil_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  cds_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output cds_pkg::out_item_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cds_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [cds_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int ColW   = cds_pkg::ColW;
  localparam int RowW   = cds_pkg::RowW;
  localparam int SizeW  = cds_pkg::SizeW;
  localparam int HSizeW = cds_pkg::HSizeW;
  localparam int SBits  = cds_pkg::SampleBits;
  localparam int RBits  = cds_pkg::RateFracBits;
  localparam int LimW   = cds_pkg::LimW;
  localparam int PendW  = cds_pkg::PendW;
  localparam int AccW   = cds_pkg::AccW;
  localparam int ProdW  = cds_pkg::ProdW;
  localparam int ValW   = cds_pkg::ValW;
  localparam int PtrW   = cds_pkg::OutPtrW;
  localparam int CntW   = cds_pkg::OutCntW;

  localparam logic [ColW-1:0] ClrLast = ColW'(cds_pkg::MaxWidth - 1);

  // Configuration registers
  logic [RBits-1:0]           rate_q;
  logic [LimW-1:0]            clamp_q;
  logic [cds_pkg::CfgSizeW-1:0] frame_width_q;
  logic [cds_pkg::CfgSizeW-1:0] frame_height_q;

  // Position and fill state
  logic [ColW-1:0]            col_q, col_d;
  logic [RowW-1:0]            row_q, row_d;
  logic [PendW-1:0]           pend_q, pend_d;
  logic                       primed_q, primed_d;
  logic signed [SBits-1:0]    win_q, win_d;

  // Clearing pass
  logic                       clr_busy_q;
  logic [ColW-1:0]            clr_addr_q;

  // Line memories
  logic signed [SBits-1:0]    upper_mem [cds_pkg::MaxWidth];
  logic signed [SBits-1:0]    middle_mem [cds_pkg::MaxWidth];
  logic signed [SBits-1:0]    up_rd_a_q, up_rd_b_q, mid_rd_a_q, mid_rd_b_q;
  logic [ColW-1:0]            up_ra_a, up_ra_b, mid_ra_a, mid_ra_b;
  logic                       mem_we;
  logic [ColW-1:0]            mem_wa;
  logic signed [SBits-1:0]    up_wd, mid_wd;

  // Forwarding of the write done at the same edge as the read
  logic                       fw_valid_q;
  logic [ColW-1:0]            fw_addr_q;
  logic signed [SBits-1:0]    fw_up_q, fw_mid_q;

  // Pipeline
  logic                       s1_valid_q, s2_valid_q, s3_valid_q;
  cds_pkg::fetch_t            s1_q, s1_d;
  cds_pkg::lap_t              s2_q, s2_d;
  cds_pkg::scale_t            s3_q, s3_d;

  // Output queue
  cds_pkg::out_item_t         out_fifo_q [cds_pkg::OutDepth];
  logic [PtrW-1:0]            wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]            out_cnt_q;
  logic [CntW-1:0]            credit;
  logic                       push, pop;
  cds_pkg::out_item_t         push_item;

  // Stage 0 signals
  logic                       accept, effective;
  logic [SizeW-1:0]           w_sat, xs, tc_full, col_nx;
  logic [HSizeW-1:0]          h_sat, ys, tr_full, row_nx;
  logic [ColW-1:0]            x;
  logic [RowW-1:0]            y;
  logic [PendW:0]             pend_inc;

  // Stage 1 signals
  logic [ColW-1:0]            tc_m1, tc_p1;
  logic signed [SBits-1:0]    nb_up, nb_lf, nb_c, nb_rt;
  logic signed [AccW-1:0]     sum, c4, c3;

  // Stage 3 signals
  logic signed [ProdW-1:0]    prod_rnd;
  logic signed [ValW-1:0]     v_raw, lim, v_clamped;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q         <= RBits'(cds_pkg::RateReset);
      clamp_q        <= '1;
      frame_width_q  <= cds_pkg::CfgSizeW'(cds_pkg::SizeReset);
      frame_height_q <= cds_pkg::CfgSizeW'(cds_pkg::SizeReset);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cds_pkg::CfgRate:        rate_q         <= cfg_data_i[RBits-1:0];
        cds_pkg::CfgClampLimit:  clamp_q        <= cfg_data_i[LimW-1:0];
        cds_pkg::CfgFrameWidth:  frame_width_q  <= cfg_data_i[cds_pkg::CfgSizeW-1:0];
        cds_pkg::CfgFrameHeight: frame_height_q <= cfg_data_i[cds_pkg::CfgSizeW-1:0];
      endcase
    end
  end

  // Stage 0: position, neighbour addresses and fill bookkeeping.
  always_comb begin
    if (SizeW'(frame_width_q) < SizeW'(cds_pkg::MinSize)) begin
      w_sat = SizeW'(cds_pkg::MinSize);
    end else if (SizeW'(frame_width_q) > SizeW'(cds_pkg::MaxWidth)) begin
      w_sat = SizeW'(cds_pkg::MaxWidth);
    end else begin
      w_sat = SizeW'(frame_width_q);
    end
    if (HSizeW'(frame_height_q) < HSizeW'(cds_pkg::MinSize)) begin
      h_sat = HSizeW'(cds_pkg::MinSize);
    end else if (HSizeW'(frame_height_q) > HSizeW'(cds_pkg::MaxHeight)) begin
      h_sat = HSizeW'(cds_pkg::MaxHeight);
    end else begin
      h_sat = HSizeW'(frame_height_q);
    end
  end

  assign x  = (SizeW'(col_q) >= w_sat) ? '0 : col_q;
  assign y  = (HSizeW'(row_q) >= h_sat) ? '0 : row_q;
  assign xs = SizeW'(x);
  assign ys = HSizeW'(y);

  always_comb begin
    if (x != '0) begin
      tc_full = xs - SizeW'(1);
      tr_full = (y == '0) ? h_sat - HSizeW'(1) : ys - HSizeW'(1);
    end else begin
      tc_full = w_sat - SizeW'(1);
      tr_full = (ys >= HSizeW'(2)) ? ys - HSizeW'(2) : ys + h_sat - HSizeW'(2);
    end
  end

  assign col_nx    = xs + SizeW'(1);
  assign row_nx    = ys + HSizeW'(1);
  assign effective = !in_data_i.kind || (primed_q && pend_q != '0);
  assign credit    = out_cnt_q + CntW'(s1_valid_q && s1_q.emit) + CntW'(s2_valid_q)
                   + CntW'(s3_valid_q);
  assign in_ready_o = !clr_busy_q && (credit < CntW'(cds_pkg::OutDepth));
  assign accept    = in_valid_i && in_ready_o;
  assign pend_inc  = (pend_q == '1) ? {1'b0, pend_q} : {1'b0, pend_q} + (PendW + 1)'(1);

  always_comb begin
    s1_d.emit      = primed_q;
    s1_d.tc        = tc_full[ColW-1:0];
    s1_d.top       = tr_full == '0;
    s1_d.bot       = tr_full == h_sat - HSizeW'(1);
    s1_d.le        = tc_full == '0;
    s1_d.ri        = tc_full == w_sat - SizeW'(1);
    s1_d.corner    = (s1_d.top || s1_d.bot) && (s1_d.le || s1_d.ri);
    s1_d.frame_end = s1_d.bot && s1_d.ri;
    s1_d.dn        = win_q;
  end

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    pend_d   = pend_q;
    primed_d = primed_q;
    win_d    = win_q;
    if (accept) begin
      col_d = x;
      row_d = y;
    end
    if (accept && effective) begin
      win_d = in_data_i.kind ? '0 : in_data_i.sample;
      if (col_nx >= w_sat) begin
        col_d = '0;
        row_d = (row_nx >= h_sat) ? '0 : row_nx[RowW-1:0];
      end else begin
        col_d = col_nx[ColW-1:0];
        row_d = y;
      end
      if (in_data_i.kind) begin
        pend_d = pend_q - PendW'(1);
        if (pend_d == '0) begin
          primed_d = 1'b0;
          col_d    = '0;
          row_d    = '0;
        end
      end else if (!primed_q) begin
        pend_d = pend_inc[PendW-1:0];
        if (pend_inc >= (PendW + 1)'(w_sat) + (PendW + 1)'(1)) begin
          primed_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      pend_q     <= '0;
      primed_q   <= 1'b0;
      win_q      <= '0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      pend_q   <= pend_d;
      primed_q <= primed_d;
      win_q    <= win_d;
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + ColW'(1);
        if (clr_addr_q == ClrLast) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  // Line memories: one write port, two registered read ports each.
  assign up_ra_a  = s1_d.tc;
  assign up_ra_b  = s1_d.tc - ColW'(1);
  assign mid_ra_a = s1_d.tc;
  assign mid_ra_b = s1_d.tc + ColW'(1);

  assign mem_we = clr_busy_q || s1_valid_q;
  assign mem_wa = clr_busy_q ? clr_addr_q : s1_q.tc;
  assign up_wd  = clr_busy_q ? '0 : nb_c;
  assign mid_wd = clr_busy_q ? '0 : s1_q.dn;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      upper_mem[mem_wa]  <= up_wd;
      middle_mem[mem_wa] <= mid_wd;
    end
    up_rd_a_q  <= upper_mem[up_ra_a];
    up_rd_b_q  <= upper_mem[up_ra_b];
    mid_rd_a_q <= middle_mem[mid_ra_a];
    mid_rd_b_q <= middle_mem[mid_ra_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_valid_q <= 1'b0;
    end else begin
      fw_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    fw_addr_q <= s1_q.tc;
    fw_up_q   <= nb_c;
    fw_mid_q  <= s1_q.dn;
  end

  // Stage 1: neighbours with forwarding, then the Laplacian term.
  assign tc_m1 = s1_q.tc - ColW'(1);
  assign tc_p1 = s1_q.tc + ColW'(1);

  always_comb begin
    nb_up = (fw_valid_q && fw_addr_q == s1_q.tc) ? fw_up_q : up_rd_a_q;
    nb_c  = (fw_valid_q && fw_addr_q == s1_q.tc) ? fw_mid_q : mid_rd_a_q;
    if (s1_q.le) begin
      nb_lf = '0;
    end else begin
      nb_lf = (fw_valid_q && fw_addr_q == tc_m1) ? fw_up_q : up_rd_b_q;
    end
    if (s1_q.ri) begin
      nb_rt = '0;
    end else begin
      nb_rt = (fw_valid_q && fw_addr_q == tc_p1) ? fw_mid_q : mid_rd_b_q;
    end
  end

  always_comb begin
    c4 = AccW'(nb_c) <<< 2;
    c3 = c4 - AccW'(nb_c);
    priority if (s1_q.top) begin
      sum = AccW'(nb_lf) + AccW'(nb_rt) + AccW'(s1_q.dn);
    end else if (s1_q.bot) begin
      sum = AccW'(nb_lf) + AccW'(nb_rt) + AccW'(nb_up);
    end else if (s1_q.le) begin
      sum = AccW'(nb_up) + AccW'(s1_q.dn) + AccW'(nb_rt);
    end else if (s1_q.ri) begin
      sum = AccW'(nb_up) + AccW'(s1_q.dn) + AccW'(nb_lf);
    end else begin
      sum = AccW'(nb_up) + AccW'(s1_q.dn) + AccW'(nb_lf) + AccW'(nb_rt);
    end
    s2_d.corner    = s1_q.corner;
    s2_d.frame_end = s1_q.frame_end;
    s2_d.centre    = nb_c;
    if (s1_q.top || s1_q.bot || s1_q.le || s1_q.ri) begin
      s2_d.acc = sum - c3;
    end else begin
      s2_d.acc = sum - c4;
    end
  end

  // Stage 2: scale by the rate.
  always_comb begin
    s3_d.corner    = s2_q.corner;
    s3_d.frame_end = s2_q.frame_end;
    s3_d.centre    = s2_q.centre;
    s3_d.prod      = ProdW'(s2_q.acc) * ProdW'($signed({1'b0, rate_q}));
  end

  // Stage 3: round half up, add the centre and saturate; corner cells give zero.
  always_comb begin
    prod_rnd  = s3_q.prod + ProdW'(1 << (RBits - 1));
    v_raw     = ValW'(s3_q.centre) + ValW'($signed(prod_rnd[ProdW-1:RBits]));
    lim       = $signed(ValW'(clamp_q));
    if (v_raw > lim) begin
      v_clamped = lim;
    end else if (v_raw < -lim) begin
      v_clamped = -lim;
    end else begin
      v_clamped = v_raw;
    end
    push_item.value     = s3_q.corner ? '0 : v_clamped[SBits-1:0];
    push_item.frame_end = s3_q.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept && effective;
      s2_valid_q <= s1_valid_q && s1_q.emit;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    s3_q <= s3_d;
  end

  // Output queue
  assign push        = s3_valid_q;
  assign out_valid_o = out_cnt_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = out_fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      out_cnt_q <= out_cnt_q + CntW'(push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_fifo_q[wr_ptr_q] <= push_item;
    end
  end

  `CDS_ASSERT(credit_bound_a, credit <= CntW'(cds_pkg::OutDepth))
  `CDS_ASSERT_NEVER(write_during_clear_a, clr_busy_q && s1_valid_q)
  `CDS_ASSERT(primed_owes_a, primed_q |-> pend_q != '0)
  `CDS_ASSERT(clear_length_a, $fell(clr_busy_q) |-> $past(clr_addr_q) == ClrLast)
  `CDS_ASSERT(result_follows_a, s3_valid_q |-> $past(s1_valid_q, 2) && $past(s1_q.emit, 2))

endmodule

@@ tb/diffusion_checker.sv @@
`timescale 1ns / 1ps

module diffusion_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  cds_pkg::in_item_t            in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  cds_pkg::out_item_t           out_data_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [cds_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cds_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           fail_count_o,
  output int                           owed_o,
  output int                           checked_o,
  output int                           frame_ends_o
);

  localparam int RateFracBits = cds_pkg::RateFracBits;
  localparam int SampleBits   = cds_pkg::SampleBits;
  localparam int LimW         = cds_pkg::LimW;
  localparam int CfgSizeW     = cds_pkg::CfgSizeW;
  localparam int MaxWidth     = cds_pkg::MaxWidth;
  localparam int MaxHeight    = cds_pkg::MaxHeight;
  localparam int MinSize      = cds_pkg::MinSize;
  localparam int RateReset    = cds_pkg::RateReset;
  localparam int SizeReset    = cds_pkg::SizeReset;

  localparam longint RoundHalf = longint'(1) << (RateFracBits - 1);
  localparam int     EdgeTaps  = 3;
  localparam int     InnerTaps = 4;
  localparam int     OwedMax   = (1 << cds_pkg::PendW) - 1;

  logic [RateFracBits-1:0]      rate_q;
  logic [LimW-1:0]              limit_q;
  logic [CfgSizeW-1:0]          width_q;
  logic [CfgSizeW-1:0]          height_q;
  logic signed [SampleBits-1:0] upper_line [MaxWidth];
  logic signed [SampleBits-1:0] middle_line [MaxWidth];
  logic signed [SampleBits-1:0] held_q;
  int                           col_q;
  int                           row_q;
  int                           owed_cells;
  logic                         primed_q;
  cds_pkg::out_item_t           diffused_q [$];
  cds_pkg::out_item_t           want;

  function automatic int clip_size(input logic [CfgSizeW-1:0] raw, input int hi);
    if (raw < MinSize) return MinSize;
    if (raw > hi) return hi;
    return int'(raw);
  endfunction

  task automatic diffuse_step(input cds_pkg::in_item_t item);
    int                 w, h, x, y, tc, tr;
    longint             s, up, ctr, dn, lf, rt, sum, k, v, lim;
    logic               top_e, bot_e, le_e, ri_e;
    cds_pkg::out_item_t res;
    w = clip_size(width_q, MaxWidth);
    h = clip_size(height_q, MaxHeight);
    if (col_q >= w) col_q = 0;
    if (row_q >= h) row_q = 0;
    s = item.sample;
    if (item.kind) begin
      if (!primed_q || owed_cells == 0) return;
      s = 0;
    end
    x = col_q;
    y = row_q;
    if (x >= 1) begin
      tc = x - 1;
      tr = (y == 0) ? h - 1 : y - 1;
    end else begin
      tc = w - 1;
      tr = (y >= 2) ? y - 2 : y + h - 2;
    end
    if (primed_q) begin
      up  = upper_line[tc];
      ctr = middle_line[tc];
      dn  = held_q;
      lf  = 0;
      rt  = 0;
      if (tc >= 1) lf = upper_line[tc-1];
      if (tc + 1 < w) rt = middle_line[tc+1];
      top_e = (tr == 0);
      bot_e = (tr == h - 1);
      le_e  = (tc == 0);
      ri_e  = (tc == w - 1);
      v = 0;
      if (!((top_e || bot_e) && (le_e || ri_e))) begin
        lim = longint'(limit_q);
        if (top_e) begin
          sum = lf + rt + dn;
          k   = EdgeTaps;
        end else if (bot_e) begin
          sum = lf + rt + up;
          k   = EdgeTaps;
        end else if (le_e) begin
          sum = up + dn + rt;
          k   = EdgeTaps;
        end else if (ri_e) begin
          sum = up + dn + lf;
          k   = EdgeTaps;
        end else begin
          sum = up + dn + lf + rt;
          k   = InnerTaps;
        end
        v = ctr + (((sum - k * ctr) * longint'(rate_q) + RoundHalf) >>> RateFracBits);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
      end
      res.value     = v[SampleBits-1:0];
      res.frame_end = (tr == h - 1) && (tc == w - 1);
      diffused_q.push_back(res);
    end
    upper_line[tc]  = middle_line[tc];
    middle_line[tc] = held_q;
    held_q          = s[SampleBits-1:0];
    col_q = x + 1;
    if (col_q >= w) begin
      col_q = 0;
      row_q = (y + 1 >= h) ? 0 : y + 1;
    end
    if (item.kind) begin
      owed_cells--;
      if (owed_cells == 0) begin
        primed_q = 1'b0;
        col_q    = 0;
        row_q    = 0;
      end
    end else if (!primed_q) begin
      if (owed_cells < OwedMax) owed_cells++;
      if (owed_cells >= w + 1) primed_q = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   = RateFracBits'(RateReset);
      limit_q  = '1;
      width_q  = CfgSizeW'(SizeReset);
      height_q = CfgSizeW'(SizeReset);
      for (int i = 0; i < MaxWidth; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      held_q       = '0;
      col_q        = 0;
      row_q        = 0;
      owed_cells   = 0;
      primed_q     = 1'b0;
      diffused_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      frame_ends_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (out_data_i.frame_end) frame_ends_o++;
        if (diffused_q.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual value %0d frame_end %0b",
                   $time, $signed(out_data_i.value), out_data_i.frame_end);
          fail_count_o++;
        end else begin
          want = diffused_q.pop_front();
          if (want.value !== out_data_i.value) begin
            $display("%0t: cell value mismatch, expected %0d, actual %0d",
                     $time, $signed(want.value), $signed(out_data_i.value));
            fail_count_o++;
          end
          if (want.frame_end !== out_data_i.frame_end) begin
            $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                     $time, want.frame_end, out_data_i.frame_end);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          cds_pkg::CfgRate:        rate_q   = cfg_data_i[RateFracBits-1:0];
          cds_pkg::CfgClampLimit:  limit_q  = cfg_data_i[LimW-1:0];
          cds_pkg::CfgFrameWidth:  width_q  = cfg_data_i[CfgSizeW-1:0];
          cds_pkg::CfgFrameHeight: height_q = cfg_data_i[CfgSizeW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) diffuse_step(in_data_i);
    end
    owed_o = diffused_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int SampleBits = cds_pkg::SampleBits;
  localparam int CfgIdxW    = cds_pkg::CfgIdxW;
  localparam int CfgDataW   = cds_pkg::CfgDataW;
  localparam int CfgSizeW   = cds_pkg::CfgSizeW;
  localparam int MinSize    = cds_pkg::MinSize;
  localparam int MaxWidth   = cds_pkg::MaxWidth;
  localparam int MaxHeight  = cds_pkg::MaxHeight;
  localparam int SizeReset  = cds_pkg::SizeReset;

  localparam int CycleLimit  = 300000;
  localparam int RandomItems = 260;
  localparam int IdlePercent = 34;
  localparam int WideWidth   = 96;

  localparam logic [SampleBits-1:0] SampleMax = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic [SampleBits-1:0] SampleMin = {1'b1, {(SampleBits-1){1'b0}}};

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  cds_pkg::in_item_t   in_data;
  logic                out_valid;
  logic                out_ready;
  cds_pkg::out_item_t  out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                calm;

  int fail_count, owed, checked, frame_ends;
  int cycle_count = 0;
  int sent, flushes, phase_count, first_random, grid_w, grid_h, cells, count;

  clamped_diffusion_stencil_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  diffusion_checker cell_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .owed_o       (owed),
    .checked_o    (checked),
    .frame_ends_o (frame_ends)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IdlePercent);
  end

  function automatic int fit_size(input int value, input int hi);
    int raw;
    raw = value & ((1 << CfgSizeW) - 1);
    if (raw < MinSize) return MinSize;
    return (raw > hi) ? hi : raw;
  endfunction

  function automatic int pick_size();
    return ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
  endfunction

  function automatic logic [SampleBits-1:0] edge_sample(input int idx);
    case (idx)
      0, 2, 6: return SampleMax;
      1, 3, 5: return SampleMin;
      7:       return SampleBits'(1);
      8:       return '1;
      default: return '0;
    endcase
  endfunction

  function automatic logic [SampleBits-1:0] any_sample();
    case ($urandom_range(7))
      0:       return SampleMax;
      1:       return SampleMin;
      2, 3:    return SampleBits'($urandom_range(8191)) - SampleBits'(4096);
      default: return SampleBits'($urandom);
    endcase
  endfunction

  // Every task starts and ends at a falling edge without having driven anything there yet.
  task automatic send_item(input logic kind, input logic [SampleBits-1:0] smp);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data.kind   <= kind;
    in_data.sample <= smp;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
    if (kind) flushes++;
  endtask

  task automatic cfg_write(input cds_pkg::cfg_reg_e idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    if (idx == cds_pkg::CfgFrameWidth) grid_w = fit_size(value, MaxWidth);
    if (idx == cds_pkg::CfgFrameHeight) grid_h = fit_size(value, MaxHeight);
  endtask

  // A transfer that owes no result may still be in flight when the last result leaves.
  task automatic settle();
    in_valid <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = cds_pkg::CfgRate;
    cfg_data    = '0;
    calm        = 1'b0;
    sent        = 0;
    flushes     = 0;
    phase_count = 0;
    grid_w      = SizeReset;
    grid_h      = SizeReset;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cfg_write(cds_pkg::CfgFrameWidth, 3);
    cfg_write(cds_pkg::CfgFrameHeight, 3);
    cfg_write(cds_pkg::CfgRate, 65535);
    cfg_write(cds_pkg::CfgClampLimit, 8388607);
    cfg_valid <= 1'b0;
    send_item(1'b1, '1);
    for (int i = 0; i < 9; i++) begin
      send_item(1'b0, edge_sample(i));
      if (i == 1) send_item(1'b1, '0);
    end
    repeat (4) send_item(1'b1, SampleBits'($urandom));
    settle();

    cfg_write(cds_pkg::CfgRate, 32768);
    cfg_write(cds_pkg::CfgClampLimit, 1);
    cfg_valid <= 1'b0;
    for (int i = 8; i >= 2; i--) send_item(1'b0, edge_sample(i));
    repeat (4) send_item(1'b1, '0);
    settle();

    calm <= 1'b1;
    cfg_write(cds_pkg::CfgFrameWidth, WideWidth);
    cfg_write(cds_pkg::CfgFrameHeight, 2047);
    cfg_write(cds_pkg::CfgRate, $urandom_range(65535));
    cfg_write(cds_pkg::CfgClampLimit, 8388607);
    cfg_valid <= 1'b0;
    repeat (WideWidth + 6) send_item(1'b0, any_sample());
    repeat (WideWidth + 2) send_item(1'b1, SampleBits'($urandom));
    settle();

    first_random = sent;
    for (int p = 0; sent - first_random < RandomItems; p++) begin
      phase_count++;
      calm <= (p == 2);
      if (p == 0) begin
        cfg_write(cds_pkg::CfgRate, 0);
        cfg_write(cds_pkg::CfgFrameWidth, 0);
        cfg_write(cds_pkg::CfgFrameHeight, 2);
      end else if (p == 1) begin
        cfg_write(cds_pkg::CfgRate, 65535);
        cfg_write(cds_pkg::CfgClampLimit, 0);
        cfg_write(cds_pkg::CfgFrameWidth, 1023);
        cfg_write(cds_pkg::CfgFrameWidth, 5);
      end else begin
        if ($urandom_range(1)) begin
          cfg_write(cds_pkg::CfgRate,
                    ($urandom_range(3) == 0) ? 65535 * $urandom_range(1)
                                             : $urandom_range(65535));
        end
        if ($urandom_range(1)) begin
          case ($urandom_range(3))
            0:       cfg_write(cds_pkg::CfgClampLimit, 8388607);
            1:       cfg_write(cds_pkg::CfgClampLimit, $urandom_range(4096));
            default: cfg_write(cds_pkg::CfgClampLimit, $urandom_range(8388607));
          endcase
        end
        if ($urandom_range(2) != 0) cfg_write(cds_pkg::CfgFrameWidth, pick_size());
        if ($urandom_range(2) != 0) cfg_write(cds_pkg::CfgFrameHeight, pick_size());
      end
      cfg_valid <= 1'b0;
      cells = grid_w * grid_h;
      count = $urandom_range(1, 2) * cells + $urandom_range(cells);
      repeat (count) begin
        if ($urandom_range(99) < 3) send_item(1'b1, SampleBits'($urandom));
        send_item(1'b0, any_sample());
      end
      // Mostly a full drain; otherwise the next phase may resize a grid left part-way through.
      if ($urandom_range(3) != 0) begin
        repeat (grid_w + 1 + $urandom_range(2)) send_item(1'b1, SampleBits'($urandom));
      end else begin
        repeat ($urandom_range(grid_w)) send_item(1'b1, SampleBits'($urandom));
      end
      settle();
    end

    $display("Sent %0d input transfers (%0d flush ticks) over %0d random setting phases.",
             sent, flushes, phase_count);
    $display("Checked %0d diffused cells, %0d of them closing a frame.", checked, frame_ends);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
